>>> hdl/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg
// Types and constants shared by the letter cipher front end, back end, top
// level and checker.
// ----------------------------------------------------------------------------
package vlc_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
    localparam logic [1:0] REG_SHIFTS_LOW  = 2'd2;
    localparam logic [1:0] REG_SHIFTS_HIGH = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_LEN_ZERO    = 2'd1;
    localparam logic [1:0] ST_SHIFT_RANGE = 2'd2;
    localparam logic [1:0] ST_UNUSED      = 2'd3;

    localparam logic [15:0] CH_UPPER_A = 16'h0041;
    localparam logic [15:0] CH_UPPER_Z = 16'h005A;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;
    localparam logic [15:0] CH_LOWER_Z = 16'h007A;

    localparam logic [5:0] ALPHA       = 6'd26;
    localparam logic [4:0] SHIFT_LIMIT = 5'd25;

    typedef struct packed {
        logic [15:0] char_in;
        logic        start_of_message;
    } t_vlc_in;

    typedef struct packed {
        logic [15:0] char_out;
        logic [1:0]  status;
    } t_vlc_out;

    typedef struct packed {
        logic        mode;
        logic [4:0]  key_length;
        logic [39:0] key_shifts_low;
        logic [39:0] key_shifts_high;
    } t_vlc_cfg;

    // classified item handed from front end to back end
    typedef struct packed {
        logic [15:0] ch;
        logic        letter;
        logic        upper;
        logic [4:0]  shift;
        logic        decrypt;
        logic [1:0]  status;
    } t_vlc_work;

endpackage

>>> hdl/vlc_fifo.sv
// ----------------------------------------------------------------------------
// vlc_fifo
// Small flop-based queue with full and empty flags. DEPTH is a power of two.
// ----------------------------------------------------------------------------
module vlc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> hdl/vlc_front.sv
// ----------------------------------------------------------------------------
// vlc_front
// Classifies each incoming character, checks the key setup and tracks the
// key position; emits a work item with the shift to apply.
// ----------------------------------------------------------------------------
module vlc_front #(
    parameter int KEY_MAX = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vlc_pkg::t_vlc_cfg   i_cfg,
    input  logic                i_take,
    input  vlc_pkg::t_vlc_in    i_item,
    output vlc_pkg::t_vlc_work  o_work
);
    import vlc_pkg::*;

    localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [4:0]       w_shift [KEY_MAX];
    logic [79:0]      w_all_shifts;
    logic [4:0]       w_len;
    logic             w_bad_shift;
    logic [1:0]       w_status;
    logic             w_upper;
    logic             w_lower;
    logic [POS_W-1:0] w_pos0;
    logic [POS_W-1:0] w_pos1;
    logic [4:0]       w_pos_inc;
    logic [POS_W-1:0] w_pos2;
    logic [POS_W-1:0] r_pos, n_pos;

    assign w_all_shifts = {i_cfg.key_shifts_high, i_cfg.key_shifts_low};
    assign w_len = (i_cfg.key_length > 5'(KEY_MAX)) ? 5'(KEY_MAX) : i_cfg.key_length;

    always_comb begin
        w_bad_shift = 1'b0;
        for (int i = 0; i < KEY_MAX; i++) begin
            w_shift[i] = w_all_shifts[5*i +: 5];
            if ((w_shift[i] > SHIFT_LIMIT) && (5'(i) < w_len)) begin
                w_bad_shift = 1'b1;
            end
        end
    end

    always_comb begin
        if (w_len == 5'd0) begin
            w_status = ST_LEN_ZERO;
        end else if (w_bad_shift) begin
            w_status = ST_SHIFT_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_upper = (i_item.char_in >= CH_UPPER_A) && (i_item.char_in <= CH_UPPER_Z);
    assign w_lower = (i_item.char_in >= CH_LOWER_A) && (i_item.char_in <= CH_LOWER_Z);

    // rewind, then pull back a position left stale by a shorter key
    assign w_pos0    = i_item.start_of_message ? '0 : r_pos;
    assign w_pos1    = (5'(w_pos0) >= w_len) ? '0 : w_pos0;
    assign w_pos_inc = 5'(w_pos1) + 5'd1;
    assign w_pos2    = (w_pos_inc >= w_len) ? '0 : w_pos_inc[POS_W-1:0];

    always_comb begin
        n_pos = r_pos;
        if (i_take) begin
            if (w_status != ST_OK) begin
                n_pos = w_pos0;
            end else if (w_upper || w_lower) begin
                n_pos = w_pos2;
            end else begin
                n_pos = w_pos1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        o_work.ch      = i_item.char_in;
        o_work.letter  = (w_upper || w_lower) && (w_status == ST_OK);
        o_work.upper   = w_upper;
        o_work.shift   = w_shift[w_pos1];
        o_work.decrypt = i_cfg.mode;
        o_work.status  = w_status;
    end

endmodule

>>> hdl/vlc_back.sv
// ----------------------------------------------------------------------------
// vlc_back
// Applies the key shift to a classified letter, modulo 26 within its case,
// and moves the result to the output queue.
// ----------------------------------------------------------------------------
module vlc_back (
    input  vlc_pkg::t_vlc_work i_work,
    input  logic               i_valid,
    input  logic               i_out_full,
    output logic               o_take,
    output vlc_pkg::t_vlc_out  o_result
);
    import vlc_pkg::*;

    logic [7:0] w_base;
    logic [4:0] w_off;
    logic [5:0] w_sum;
    logic [5:0] w_wrap;
    logic [7:0] w_letter;

    assign o_take = i_valid & ~i_out_full;

    assign w_base = i_work.upper ? CH_UPPER_A[7:0] : CH_LOWER_A[7:0];
    assign w_off  = 5'(i_work.ch[7:0] - w_base);

    always_comb begin
        if (i_work.decrypt) begin
            w_sum = 6'(w_off) + ALPHA - 6'(i_work.shift);
        end else begin
            w_sum = 6'(w_off) + 6'(i_work.shift);
        end
        w_wrap   = (w_sum >= ALPHA) ? (w_sum - ALPHA) : w_sum;
        w_letter = w_base + 8'(w_wrap);
    end

    always_comb begin
        o_result.char_out = i_work.letter ? {8'h00, w_letter} : i_work.ch;
        o_result.status   = i_work.status;
    end

endmodule

>>> hdl/vigenere_letter_cipher.sv
// ----------------------------------------------------------------------------
// vigenere_letter_cipher
// Vigenere shift of a 16-bit character stream over ASCII letters, with an
// APB register port for mode, key length and key shifts.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     push / full                i_data  (char_in, start_of_message)
//  result    pop / empty                o_data  (char_out, status)
//  config    psel penable pwrite pready paddr, pwdata, prdata
//
//  one character per cycle sustained while results are popped; a result
//  is visible once it is shifted from the classify queue into the result queue
//  the key position counter in the front end is a register updated on each accepted character
//  reset clears both queues, the key position and the configuration registers
//  a stalled result queue fills the classify queue, then raises full
// ----------------------------------------------------------------------------
module vigenere_letter_cipher #(
    parameter int KEY_MAX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  vlc_pkg::t_vlc_in                    i_data,
    input  logic                                pop,
    output logic                                empty,
    output vlc_pkg::t_vlc_out                   o_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vlc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [vlc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [vlc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import vlc_pkg::*;

    localparam int WORK_W = $bits(t_vlc_work);
    localparam int OUT_W  = $bits(t_vlc_out);

    t_vlc_cfg   r_cfg;
    logic [1:0] w_reg_idx;
    logic       w_cfg_wr;
    logic       w_take_in;
    t_vlc_work  w_work_in;
    t_vlc_work  w_work_out;
    logic       w_mid_full;
    logic       w_mid_empty;
    logic       w_back_take;
    logic       w_res_full;
    t_vlc_out   w_result;

    // register file
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:3];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_MODE:        r_cfg.mode            <= pwdata[0];
                REG_KEY_LENGTH:  r_cfg.key_length      <= pwdata[4:0];
                REG_SHIFTS_LOW:  r_cfg.key_shifts_low  <= pwdata[39:0];
                REG_SHIFTS_HIGH: r_cfg.key_shifts_high <= pwdata[39:0];
                default:         r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MODE:        prdata = {63'd0, r_cfg.mode};
            REG_KEY_LENGTH:  prdata = {59'd0, r_cfg.key_length};
            REG_SHIFTS_LOW:  prdata = {24'd0, r_cfg.key_shifts_low};
            REG_SHIFTS_HIGH: prdata = {24'd0, r_cfg.key_shifts_high};
            default:         prdata = '0;
        endcase
    end

    assign full      = w_mid_full;
    assign w_take_in = push & ~w_mid_full;

    vlc_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (w_take_in),
        .i_item  (i_data),
        .o_work  (w_work_in)
    );

    vlc_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take_in),
        .i_wdata (w_work_in),
        .o_full  (w_mid_full),
        .i_pop   (w_back_take),
        .o_rdata (w_work_out),
        .o_empty (w_mid_empty)
    );

    vlc_back u_back (
        .i_work     (w_work_out),
        .i_valid    (~w_mid_empty),
        .i_out_full (w_res_full),
        .o_take     (w_back_take),
        .o_result   (w_result)
    );

    vlc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_back_take),
        .i_wdata (w_result),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (o_data),
        .o_empty (empty)
    );

endmodule

>>> hdl/vlc_checker.sv
// ----------------------------------------------------------------------------
// vlc_checker
// Port-level checks on the letter cipher, bound to the top level.
// ----------------------------------------------------------------------------
module vlc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    input  logic                            full,
    input  vlc_pkg::t_vlc_in                i_data,
    input  logic                            pop,
    input  logic                            empty,
    input  vlc_pkg::t_vlc_out               o_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vlc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [vlc_pkg::CFG_DATA_W-1:0]  pwdata,
    input  logic [vlc_pkg::CFG_DATA_W-1:0]  prdata,
    input  logic                            pready
);
    import vlc_pkg::*;

    // reset drains both queues
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.status != ST_UNUSED))
        else $error("undefined status code on result");

    // input backs up only behind a waiting result
    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input stalled with no result waiting");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("waiting result beat changed");

endmodule

bind vigenere_letter_cipher vlc_checker u_vlc_checker (.*);
